FILE: hdl/pfd_pkg.sv
// pfd_pkg: shared types, codes and header layout constants for the frame deframer
`default_nettype none

package pfd_pkg;

    // byte position counter
    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // header layout
    localparam logic [POS_W-1:0] MAGIC_LEN = 17'd4;
    localparam logic [POS_W-1:0] PRIO_POS  = 17'd4;
    localparam logic [POS_W-1:0] LEN_POS   = 17'd13;
    localparam logic [POS_W-1:0] HDR_LEN   = 17'd15;
    localparam logic [7:0]       PRIO_MAX  = 8'd7;

    // magic bytes 'T' 'S' 'N' '1'
    localparam logic [7:0] MAGIC_0 = 8'h54;
    localparam logic [7:0] MAGIC_1 = 8'h53;
    localparam logic [7:0] MAGIC_2 = 8'h4E;
    localparam logic [7:0] MAGIC_3 = 8'h31;

    // byte kind codes
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_PAY  = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    // end-of-packet status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_SHORT     = 2'd1;
    localparam logic [1:0] STAT_BAD_MAGIC = 2'd2;
    localparam logic [1:0] STAT_TRUNC     = 2'd3;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_out;
        logic        done_res;
        logic [1:0]  status;
        logic [2:0]  priority_res;
        logic [63:0] sequence_res;
        logic [15:0] stream_length;
    } t_result;

    // expected magic byte at a header position
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = MAGIC_0;
            2'd1:    b = MAGIC_1;
            2'd2:    b = MAGIC_2;
            default: b = MAGIC_3;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pfd_ifs.sv
// pfd_ifs: byte input and result output handshake channels
`default_nettype none

interface pfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

interface pfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_out;
    logic        done_res;
    logic [1:0]  status;
    logic [2:0]  priority_res;
    logic [63:0] sequence_res;
    logic [15:0] stream_length;

    modport source (output valid, output kind, output data_out, output done_res,
                    output status, output priority_res, output sequence_res,
                    output stream_length, input ready);
    modport sink   (input valid, input kind, input data_out, input done_res,
                    input status, input priority_res, input sequence_res,
                    input stream_length, output ready);
endinterface

`default_nettype wire

FILE: hdl/pfd_hdr_tracker.sv
// pfd_hdr_tracker: per-packet header state and per-byte classification
`default_nettype none

module pfd_hdr_tracker
    import pfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data,
    input  wire logic       i_last,
    output t_result         o_result
);

    logic [POS_W-1:0] r_pos;
    logic             r_magic_good;
    logic [2:0]       r_prio;
    logic [63:0]      r_seq;
    logic [15:0]      r_name_len;

    logic             n_magic_good;
    logic [2:0]       n_prio;
    logic [63:0]      n_seq;
    logic [15:0]      n_name_len;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] name_off;
    logic [POS_W-1:0] need_len;
    logic [1:0]       kind;
    logic [1:0]       status;

    // header field capture for this byte
    always_comb begin
        n_magic_good = r_magic_good;
        n_prio       = r_prio;
        n_seq        = r_seq;
        n_name_len   = r_name_len;
        if (r_pos < MAGIC_LEN) begin
            if (i_data != magic_byte(r_pos[1:0])) begin
                n_magic_good = 1'b0;
            end
        end else if (r_pos == PRIO_POS) begin
            n_prio = (i_data > PRIO_MAX) ? PRIO_MAX[2:0] : i_data[2:0];
        end else if (r_pos < LEN_POS) begin
            n_seq = {r_seq[55:0], i_data};
        end else if (r_pos < HDR_LEN) begin
            n_name_len = {r_name_len[7:0], i_data};
        end
    end

    // saturating count and length compares
    assign n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign name_off = r_pos - HDR_LEN;
    assign need_len = {1'b0, n_name_len} + HDR_LEN;

    // byte kind
    always_comb begin
        priority if (!n_magic_good) begin
            kind = KIND_DROP;
        end else if (r_pos < HDR_LEN) begin
            kind = KIND_HDR;
        end else if (name_off < {1'b0, n_name_len}) begin
            kind = KIND_NAME;
        end else begin
            kind = KIND_PAY;
        end
    end

    // end-of-packet status, faults in priority order
    always_comb begin
        status = STAT_OK;
        if (i_last) begin
            priority if (n_pos < HDR_LEN) begin
                status = STAT_SHORT;
            end else if (!n_magic_good) begin
                status = STAT_BAD_MAGIC;
            end else if (n_pos < need_len) begin
                status = STAT_TRUNC;
            end else begin
                status = STAT_OK;
            end
        end
    end

    assign o_result = '{
        kind:          kind,
        data_out:      i_data,
        done_res:      i_last,
        status:        status,
        priority_res:  n_prio,
        sequence_res:  n_seq,
        stream_length: n_name_len
    };

    // packet state, cleared at the end of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_magic_good <= 1'b1;
            r_prio       <= '0;
            r_seq        <= '0;
            r_name_len   <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_pos        <= '0;
                r_magic_good <= 1'b1;
                r_prio       <= '0;
                r_seq        <= '0;
                r_name_len   <= '0;
            end else begin
                r_pos        <= n_pos;
                r_magic_good <= n_magic_good;
                r_prio       <= n_prio;
                r_seq        <= n_seq;
                r_name_len   <= n_name_len;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pubsub_frame_deframer_core.sv
// pubsub_frame_deframer_core: top level of the packet header deframer
`default_nettype none

// Takes one packet byte per cycle and returns one result item per byte; each
// byte passes an input register, then the result register. While the
// consumer takes results, the sustained rate is one byte per clock: the header
// state is updated in the single cycle in which a byte moves from the input
// register into the result register, so the next byte sees it at once. Both
// registers keep advancing while the consumer takes results; a stall on the
// output fills the result register and then the input register before ready
// drops. Bytes are forwarded before the packet is validated: the consumer must
// drop a packet whose final item has a status other than ok. Priority, sequence
// and stream length are meaningful only on the final item of a good packet.
module pubsub_frame_deframer_core
    import pfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfd_in_if.sink    i_in,
    pfd_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       step;
    t_result    result;

    // pipeline flow control
    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_data <= i_in.data;
            r_in_last <= i_in.last;
        end
    end

    // header tracking and classification
    pfd_hdr_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_data   (r_in_data),
        .i_last   (r_in_last),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    // output channel
    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.data_out      = r_out.data_out;
    assign o_out.done_res      = r_out.done_res;
    assign o_out.status        = r_out.status;
    assign o_out.priority_res  = r_out.priority_res;
    assign o_out.sequence_res  = r_out.sequence_res;
    assign o_out.stream_length = r_out.stream_length;

endmodule

`default_nettype wire

FILE: hdl/pfd_checker.sv
// pfd_checker: port-level assertions for the deframer, bound to the top level
`default_nettype none

module pfd_checker
    import pfd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_kind,
    input wire logic [7:0]  i_data_out,
    input wire logic        i_done_res,
    input wire logic [1:0]  i_status
);

    // no result item right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_out)
            && $stable(i_kind) && $stable(i_status) && $stable(i_done_res))
        else $error("stalled result item changed");

    // status only on the final item
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_done_res |-> i_status == STAT_OK)
        else $error("status set on a non-final item");

    // a discarded final byte never reports ok
    a_drop_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res && i_kind == KIND_DROP |-> i_status != STAT_OK)
        else $error("bad magic packet reported ok");

    // a final header byte has good magic so never reports bad magic
    a_hdr_end_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res && i_kind == KIND_HDR |-> i_status != STAT_BAD_MAGIC)
        else $error("packet ending in header reported bad magic");

endmodule

bind pubsub_frame_deframer_core pfd_checker u_pfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_data_out  (o_out.data_out),
    .i_done_res  (o_out.done_res),
    .i_status    (o_out.status)
);

`default_nettype wire

FILE: tb/pfd_byte_checker.sv
// pfd_byte_checker: watches both channels, predicts each result item and compares it
`default_nettype none

module pfd_byte_checker
    import pfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfd_in_if         i_in,
    pfd_out_if        i_out,
    output int        o_mismatches,
    output int        o_outstanding
);

    // magic bytes packed first to last
    localparam logic [31:0] MAGIC_WORD = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
    localparam int          SHOW_MAX   = 10;

    // predicted packet state
    logic [POS_W-1:0] pkt_pos;
    logic             magic_seen_ok;
    logic [2:0]       hdr_prio;
    logic [63:0]      hdr_seq;
    logic [15:0]      hdr_name_len;

    t_result expected_tags[$];
    int      errs;

    task automatic clear_packet_state();
        pkt_pos       = '0;
        magic_seen_ok = 1'b1;
        hdr_prio      = '0;
        hdr_seq       = '0;
        hdr_name_len  = '0;
    endtask

    // work out the result item caused by one accepted byte
    task automatic deframe_byte(input logic [7:0] d, input logic l, output t_result r);
        int unsigned p;
        int unsigned count;
        p = pkt_pos;
        if (pkt_pos < MAGIC_LEN) begin
            if (d != MAGIC_WORD[31 - 8*p -: 8]) magic_seen_ok = 1'b0;
        end else if (pkt_pos == PRIO_POS) begin
            hdr_prio = (d > PRIO_MAX) ? PRIO_MAX[2:0] : d[2:0];
        end else if (pkt_pos < LEN_POS) begin
            hdr_seq = {hdr_seq[55:0], d};
        end else if (pkt_pos < HDR_LEN) begin
            hdr_name_len = {hdr_name_len[7:0], d};
        end

        r = '0;
        r.data_out = d;
        r.done_res = l;
        if (!magic_seen_ok) begin
            r.kind = KIND_DROP;
        end else if (pkt_pos < HDR_LEN) begin
            r.kind = KIND_HDR;
        end else if (p - 32'(HDR_LEN) < 32'(hdr_name_len)) begin
            r.kind = KIND_NAME;
        end else begin
            r.kind = KIND_PAY;
        end

        // byte count saturates
        count = (pkt_pos < POS_MAX) ? p + 1 : p;

        r.status = STAT_OK;
        if (l) begin
            if (count < 32'(HDR_LEN)) begin
                r.status = STAT_SHORT;
            end else if (!magic_seen_ok) begin
                r.status = STAT_BAD_MAGIC;
            end else if (count < 32'(HDR_LEN) + 32'(hdr_name_len)) begin
                r.status = STAT_TRUNC;
            end
        end
        r.priority_res  = hdr_prio;
        r.sequence_res  = hdr_seq;
        r.stream_length = hdr_name_len;

        if (l) begin
            clear_packet_state();
        end else begin
            pkt_pos = count[POS_W-1:0];
        end
    endtask

    task automatic show_item(input string tag, input t_result r);
        $display("  %s kind=%0d data=%02h done=%0b status=%0d prio=%0d seq=%016h len=%0d",
                 tag, r.kind, r.data_out, r.done_res, r.status, r.priority_res,
                 r.sequence_res, r.stream_length);
    endtask

    // predict on input handshakes, compare on output handshakes
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        logic    bad;
        if (!i_rst_n) begin
            clear_packet_state();
            expected_tags.delete();
            errs = 0;
            o_mismatches  <= 0;
            o_outstanding <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                deframe_byte(i_in.data, i_in.last, want);
                expected_tags.insert(expected_tags.size(), want);
            end
            if (i_out.valid && i_out.ready) begin
                got.kind          = i_out.kind;
                got.data_out      = i_out.data_out;
                got.done_res      = i_out.done_res;
                got.status        = i_out.status;
                got.priority_res  = i_out.priority_res;
                got.sequence_res  = i_out.sequence_res;
                got.stream_length = i_out.stream_length;
                if (expected_tags.size() == 0) begin
                    errs++;
                    if (errs <= SHOW_MAX) begin
                        $display("%0t: result item with nothing expected", $time);
                        show_item("got ", got);
                    end
                end else begin
                    want = expected_tags.pop_front();
                    bad = (got.kind          !== want.kind)
                       || (got.data_out      !== want.data_out)
                       || (got.done_res      !== want.done_res)
                       || (got.status        !== want.status)
                       || (got.priority_res  !== want.priority_res)
                       || (got.sequence_res  !== want.sequence_res)
                       || (got.stream_length !== want.stream_length);
                    if (bad) begin
                        errs++;
                        if (errs <= SHOW_MAX) begin
                            $display("%0t: result item mismatch", $time);
                            show_item("want", want);
                            show_item("got ", got);
                        end
                    end
                end
            end
            o_mismatches  <= errs;
            o_outstanding <= expected_tags.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_pubsub_frame_deframer_core.sv
// tb_pubsub_frame_deframer_core: packet stimulus, output stalls and verdict for the deframer
`default_nettype none

module tb_pubsub_frame_deframer_core;
    import pfd_pkg::*;

    localparam int          RANDOM_ITEMS = 1730;
    localparam int          LONG_HOLD    = 400;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam logic [31:0] GOOD_MAGIC   = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};

    logic i_clk;
    logic i_rst_n;

    pfd_in_if  in_ch ();
    pfd_out_if out_ch ();

    int mismatches;
    int outstanding;
    int sent_count;
    int cycles;

    logic [7:0] pkt_bytes[$];

    pubsub_frame_deframer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pfd_byte_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // reset at start, then released
    initial begin
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // run limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    task automatic wait_out_of_reset();
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
    endtask

    // offer one byte and hold it until accepted
    task automatic drive_byte(input logic [7:0] d, input logic l);
        in_ch.valid <= 1'b1;
        in_ch.data  <= d;
        in_ch.last  <= l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_packet(input bit gappy);
        int g;
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            drive_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
            g = gappy ? pick_gap() : 0;
            if (g > 0) begin
                in_ch.valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        pkt_bytes.delete();
    endtask

    // append one byte to the packet being built
    task automatic add_byte(input logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endtask

    task automatic add_header(input logic [31:0] magic, input logic [7:0] prio,
                              input logic [63:0] seq, input logic [15:0] name_len);
        for (int i = 3; i >= 0; i--) add_byte(magic[8*i +: 8]);
        add_byte(prio);
        for (int i = 7; i >= 0; i--) add_byte(seq[8*i +: 8]);
        add_byte(name_len[15:8]);
        add_byte(name_len[7:0]);
    endtask

    task automatic add_random_bytes(input int n);
        for (int i = 0; i < n; i++) add_byte(8'($urandom));
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // mostly well-formed packets, some corrupted, cut short or plain noise
    task automatic random_packet();
        int          r;
        int          name_len;
        int          body;
        int          cut;
        logic [31:0] magic;
        r = $urandom_range(99);
        if (r < 6) begin
            add_random_bytes($urandom_range(20, 1));
        end else begin
            magic = GOOD_MAGIC;
            if (r < 14) magic[8*$urandom_range(3) +: 8] = 8'($urandom);
            r = $urandom_range(99);
            if (r < 80) name_len = $urandom_range(6);
            else if (r < 95) name_len = $urandom_range(40, 7);
            else name_len = $urandom_range(65535);
            add_header(magic, 8'($urandom), {$urandom, $urandom}, 16'(name_len));
            body = (name_len <= 40) ? name_len + $urandom_range(10) : $urandom_range(20);
            add_random_bytes(body);
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(pkt_bytes.size(), 1);
                pkt_bytes = pkt_bytes[0:cut-1];
            end
        end
        send_packet($urandom_range(3) != 0);
        if ($urandom_range(1)) begin
            in_ch.valid <= 1'b0;
            repeat (pick_gap() + 1) @(posedge i_clk);
        end
    endtask

    // result side: random stalls, two long hold-offs while bytes keep coming
    initial begin
        int hold_stage;
        int hold_at[2];
        int n;
        hold_at[0] = 300;
        hold_at[1] = 1200;
        hold_stage = 0;
        out_ch.ready <= 1'b0;
        wait_out_of_reset();
        forever begin
            if (hold_stage < 2 && sent_count >= hold_at[hold_stage]) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_stage++;
            end
            out_ch.ready <= 1'b1;
            n = ($urandom_range(9) == 0) ? $urandom_range(200, 50) : $urandom_range(8, 1);
            repeat (n) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int  stop_at;
        bit  mid_drain_done;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        in_ch.last  <= 1'b0;
        sent_count = 0;
        wait_out_of_reset();

        // single-byte packets: too short wins over bad magic
        add_byte(8'hFF);
        send_packet(1'b0);
        add_byte(MAGIC_0);
        send_packet(1'b0);
        // good packet, priority clamp, all-ones sequence, name then payload
        add_header(GOOD_MAGIC, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2);
        add_byte(8'h61);
        add_byte(8'h62);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h55);
        send_packet(1'b0);
        // bare header, exactly long enough
        add_header(GOOD_MAGIC, 8'h07, 64'h0, 16'd0);
        send_packet(1'b1);
        // name cut short
        add_header(GOOD_MAGIC, 8'h00, 64'h0123_4567_89AB_CDEF, 16'd3);
        add_byte(8'hAA);
        send_packet(1'b0);
        // bad magic wins over a truncated name
        add_header({MAGIC_0, MAGIC_1, 8'h00, MAGIC_3}, 8'h03, 64'h5A5A, 16'h0010);
        send_packet(1'b0);
        // one byte short of a header
        add_header(GOOD_MAGIC, 8'h01, 64'h8000_0000_0000_0001, 16'd0);
        void'(pkt_bytes.pop_back());
        send_packet(1'b0);
        // mismatch on the final magic byte
        add_header({MAGIC_0, MAGIC_1, MAGIC_2, 8'h32}, 8'h02, 64'h1, 16'd0);
        add_random_bytes(2);
        send_packet(1'b1);
        // largest name length, clamped priority eight
        add_header(GOOD_MAGIC, 8'h08, 64'h8000_0000_0000_0001, 16'hFFFF);
        add_random_bytes(3);
        send_packet(1'b0);
        wait_drained();

        // random packets
        stop_at = sent_count + RANDOM_ITEMS;
        mid_drain_done = 1'b0;
        while (sent_count < stop_at) begin
            random_packet();
            if (!mid_drain_done && sent_count >= stop_at - RANDOM_ITEMS / 2) begin
                wait_drained();
                mid_drain_done = 1'b1;
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
